/* hdl/lndp_pkg.sv */
// Package for the log-domain neuron MAC: sizes, queue item type and the
// exp2 / log2-threshold ROMs, built at elaboration from a Q2.62 root table.
// No dependencies.
package lndp_pkg;

  localparam int LOG_BITS = 8;
  localparam int LOG_FRAC = 4;
  localparam int SUM_FRAC = 8;

  localparam int FIELD_W   = 8;
  localparam int BIAS_W    = 24;
  localparam int ACC_W     = 32;
  localparam int LIN_W     = 31;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 32;

  localparam int LOG_USE   = (LOG_BITS < FIELD_W) ? LOG_BITS : FIELD_W;
  localparam int LWX_W     = LOG_USE + 1;
  localparam int SUMW      = SUM_FRAC + 2;
  localparam int AW        = SUM_FRAC + 1;
  localparam int EXP_DEPTH = (SUM_FRAC + 2) << LOG_FRAC;
  localparam int EXP_AW    = $clog2(EXP_DEPTH);
  localparam int THR_DEPTH = 1 << LOG_BITS;
  localparam logic [LOG_BITS-1:0] LOG_MASK = {LOG_BITS{1'b1}};
  localparam logic [AW-1:0] CAP = AW'(1) << SUM_FRAC;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int ROOT_COUNT = 14;
  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

  typedef struct packed {
    logic [SUMW-1:0]   summand;
    logic              neg;
    logic [BIAS_W-1:0] bias;
    logic              first;
    logic              last;
  } item_t;

  typedef struct packed {
    logic              mode;
    logic              clip;
    logic [LIN_W-1:0]  lin;
    logic [AW-1:0]     a;
    logic [LOG_BITS-1:0] lo;
    logic [LOG_BITS-1:0] hi;
  } srch_t;

  typedef logic [63:0]     root_tab_t [ROOT_COUNT];
  typedef logic [SUMW-1:0] exp_rom_t [EXP_DEPTH];
  typedef logic [AW-1:0]   thr_rom_t [THR_DEPTH];

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] sqrt_q62(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] t;
    y = '0;
    for (int b = 62; b >= 0; b--) begin
      t = y | (64'd1 << b);
      if (mul_q62(t, t) <= x) y = t;
    end
    return y;
  endfunction

  function automatic root_tab_t make_roots();
    root_tab_t r;
    r[0] = ONE_Q62 >> 1;
    for (int k = 1; k < ROOT_COUNT; k++) r[k] = sqrt_q62(r[k-1]);
    return r;
  endfunction

  localparam root_tab_t ROOT_TAB = make_roots();

  // 2^(SUM_FRAC - num/2^n) as an integer, rounded half up or floored
  function automatic logic [63:0] scaled_pow(input logic [63:0] num, input int n,
                                             input logic rounding);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] m;
    int          sh;
    q = num >> n;
    r = num & ((64'd1 << n) - 64'd1);
    if (q >= 64'(SUM_FRAC + 2)) return 64'd0;
    m = ONE_Q62;
    for (int j = 0; j < n; j++) begin
      if (r[j]) m = mul_q62(m, ROOT_TAB[n - j]);
    end
    sh = 62 - SUM_FRAC + int'(q);
    if (rounding) m = m + (64'd1 << (sh - 1));
    return m >> sh;
  endfunction

  function automatic exp_rom_t make_exp_rom();
    exp_rom_t    rom;
    logic [63:0] v;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      v = scaled_pow(64'(i), LOG_FRAC, 1'b1);
      rom[i] = v[SUMW-1:0];
    end
    return rom;
  endfunction

  function automatic thr_rom_t make_thr_rom();
    thr_rom_t    rom;
    logic [63:0] v;
    for (int i = 0; i < THR_DEPTH; i++) begin
      v = scaled_pow(64'(2 * i + 1), LOG_FRAC + 1, 1'b0);
      rom[i] = v[AW-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = make_exp_rom();
  localparam thr_rom_t THR_ROM = make_thr_rom();

endpackage

/* hdl/lndp_front.sv */
// Front end: takes input transactions, adds the two log codes and looks up
// the linear product in the exp2 ROM. Depends on lndp_pkg.
module lndp_front (
  input  logic [lndp_pkg::S_TDATA_W-1:0] s_axis_tdata, // act_log, weight_log, weight_negative, bias
  input  logic                           s_axis_tuser, // first_element
  input  logic                           s_axis_tlast,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic                           full_i,
  output logic                           push_o,
  output lndp_pkg::item_t                item_o
);
  import lndp_pkg::*;

  logic [FIELD_W-1:0] act_log;
  logic [FIELD_W-1:0] weight_log;
  logic [LWX_W-1:0]   lwx;
  logic [EXP_AW-1:0]  rom_idx;

  assign act_log    = s_axis_tdata[FIELD_W-1:0];
  assign weight_log = s_axis_tdata[2*FIELD_W-1:FIELD_W];
  assign lwx        = LWX_W'(act_log[LOG_USE-1:0]) + LWX_W'(weight_log[LOG_USE-1:0]);
  assign rom_idx    = EXP_AW'(lwx);

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  always_comb begin
    // products smaller than the lowest fraction bit round to zero
    item_o.summand = (32'(lwx) < 32'(EXP_DEPTH)) ? EXP_ROM[rom_idx] : '0;
    item_o.neg     = s_axis_tdata[2*FIELD_W];
    item_o.bias    = s_axis_tdata[2*FIELD_W+BIAS_W:2*FIELD_W+1];
    item_o.first   = s_axis_tuser;
    item_o.last    = s_axis_tlast;
  end

endmodule

/* hdl/lndp_fifo.sv */
// Short queue of classified items between the front end and the back end.
// Depends on lndp_pkg.
module lndp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lndp_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output lndp_pkg::item_t item_o
);
  import lndp_pkg::*;

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   count_q, count_d;

  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + FIFO_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;
    count_d  = count_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* hdl/lndp_back.sv */
// Back end: saturating accumulator, pipelined binary search over the log2
// threshold ROM, and the output register. Depends on lndp_pkg.
module lndp_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           mode_i,
  input  logic                           empty_i,
  input  lndp_pkg::item_t                item_i,
  output logic                           pop_o,
  output logic [lndp_pkg::M_TDATA_W-1:0] m_axis_tdata, // activation
  output logic                           m_axis_tuser, // clipped_low
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready
);
  import lndp_pkg::*;

  logic                    adv;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [ACC_W-1:0]        base;
  logic [ACC_W:0]          sum;
  logic                    clip;
  logic                    big;

  logic [LOG_BITS:0]       vld_q, vld_d;
  srch_t                   st_q [LOG_BITS+1];
  srch_t                   st_d [LOG_BITS+1];
  logic [LOG_BITS-1:0]     mid  [LOG_BITS];

  logic                    out_valid_q, out_valid_d;
  logic [LIN_W-1:0]        out_act_q, out_act_d;
  logic                    out_clip_q, out_clip_d;

  // hold the whole back end while a result waits
  assign adv   = !out_valid_q || m_axis_tready;
  assign pop_o = adv && !empty_i;

  always_comb begin
    base = item_i.first ? ACC_W'($signed(item_i.bias)) : acc_q;
    if (item_i.neg) begin
      sum = {base[ACC_W-1], base} - (ACC_W+1)'(item_i.summand);
    end else begin
      sum = {base[ACC_W-1], base} + (ACC_W+1)'(item_i.summand);
    end
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_d = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_d = sum[ACC_W-1:0];
    end
    clip = acc_d[ACC_W-1] || (acc_d == '0);
    big  = acc_d > ACC_W'(CAP);

    st_d[0].mode = mode_i;
    st_d[0].clip = clip;
    st_d[0].lin  = acc_d[LIN_W-1:0];
    st_d[0].a    = big ? CAP : acc_d[AW-1:0];
    st_d[0].lo   = '0;
    st_d[0].hi   = LOG_MASK;
    vld_d[0]     = pop_o && item_i.last;

    // one bisection step per stage
    for (int k = 0; k < LOG_BITS; k++) begin
      mid[k]     = st_q[k].lo + ((st_q[k].hi - st_q[k].lo) >> 1);
      st_d[k+1]  = st_q[k];
      vld_d[k+1] = vld_q[k];
      if (st_q[k].lo < st_q[k].hi) begin
        if (THR_ROM[mid[k]] >= st_q[k].a) begin
          st_d[k+1].lo = mid[k] + LOG_BITS'(1);
        end else begin
          st_d[k+1].hi = mid[k];
        end
      end
    end

    out_valid_d = vld_q[LOG_BITS];
    out_clip_d  = st_q[LOG_BITS].clip;
    if (st_q[LOG_BITS].mode) begin
      out_act_d = st_q[LOG_BITS].clip ? '0 : st_q[LOG_BITS].lin;
    end else begin
      out_act_d = st_q[LOG_BITS].clip ? LIN_W'(LOG_MASK) : LIN_W'(st_q[LOG_BITS].lo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (pop_o) begin
        acc_q <= acc_d;
      end
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= LOG_BITS; k++) begin
        st_q[k] <= st_d[k];
      end
      out_act_q  <= out_act_d;
      out_clip_q <= out_clip_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_act_q);
  assign m_axis_tuser  = out_clip_q;

endmodule

/* hdl/lns_neuron_dot_product_activation.sv */
// Log-domain neuron MAC with clipped-ReLU or linear activation: top level.
// Depends on lndp_pkg, lndp_front, lndp_fifo and lndp_back.
//
//  Channel  Direction  Handshake                      Payload
//  s_axis   in         s_axis_tvalid / s_axis_tready  tdata, tuser, tlast
//  m_axis   out        m_axis_tvalid / m_axis_tready  tdata, tuser
//  cfg      in         cfg_valid_i / cfg_ready_o      cfg_data_i (last_layer_mode)
//
// One input transaction per cycle while the queue has room; the accumulator add
// and saturate is the loop that sets that rate. A result passes from the queue
// through the accumulate step, one bisection stage per log code bit and the
// output register.
// Reset clears the accumulator, the mode register and the queue.
// A stalled m_axis freezes the back end; the queue then fills and drops s_axis_tready.
module lns_neuron_dot_product_activation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // act_log [7:0], weight_log [15:8], weight_negative [16], bias [40:17]
  input  logic [lndp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tuser,  // first_element
  input  logic                           s_axis_tlast,  // last_element
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  output logic [lndp_pkg::M_TDATA_W-1:0] m_axis_tdata,  // activation [30:0]
  output logic                           m_axis_tuser,  // clipped_low
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i
);
  import lndp_pkg::*;

  logic  mode_q, mode_d;
  logic  push;
  logic  full;
  logic  pop;
  logic  empty;
  item_t front_item;
  item_t queue_item;

  assign cfg_ready_o = 1'b1;
  assign mode_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  lndp_front u_front (
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .full_i        (full),
    .push_o        (push),
    .item_o        (front_item)
  );

  lndp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (queue_item)
  );

  lndp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .empty_i       (empty),
    .item_i        (queue_item),
    .pop_o         (pop),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

endmodule

/* tb/sv/tb_lns_neuron_dot_product_activation.sv */
`timescale 1ns / 100ps
// Self-checking bench for lns_neuron_dot_product_activation: streams neuron elements,
// predicts each activation bit for bit and checks the m_axis results in order.
// Depends on lndp_pkg and the RTL of the block; needs nothing else.
module tb_lns_neuron_dot_product_activation;
  import lndp_pkg::*;

  localparam int unsigned LMASK       = (1 << LOG_BITS) - 1;
  localparam int          SETTLE      = 30;
  localparam int          HOLD_CYCLES = 400;
  localparam int          QUIET_LIMIT = 5000;
  localparam int          PHASE_ITEMS = 165;

  typedef struct packed {
    logic [7:0]  act_log;
    logic [7:0]  wt_log;
    logic        wt_neg;
    logic [23:0] bias;
    logic        first;
    logic        last;
  } neuron_in_t;

  typedef struct packed {
    logic [30:0] activation;
    logic        clipped;
  } neuron_out_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_data_i    = 1'b0;

  lns_neuron_dot_product_activation uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state and tables
  logic [63:0]     root2_q62 [0:LOG_FRAC+1];
  logic [SUMW-1:0] exp2_lin  [0:2*LMASK];
  longint          log_thresh [0:LMASK];
  int              acc_reg    = 0;
  logic            layer_mode = 1'b0;

  neuron_in_t  stim_items[$];
  neuron_out_t pending_acts[$];
  int          pushed_cnt = 0;
  int          taken_cnt  = 0;
  int          mism_cnt   = 0;
  int          src_idle_pct  = 0;
  int          snk_stall_pct = 0;
  logic        hold_go   = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  neuron_in_t  on_bus;

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] q62_sqrt(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] t;
    y = '0;
    for (int b = 62; b >= 0; b--) begin
      t = y | (64'd1 << b);
      if (q62_mul(t, t) <= x) y = t;
    end
    return y;
  endfunction

  // 2^(SUM_FRAC - num/2^n) as an integer, rounded half up or floored
  function automatic longint unsigned pow2_scaled(input int unsigned num, input int n,
                                                  input bit round_up);
    logic [63:0] m;
    int unsigned q;
    int unsigned r;
    int          sh;
    q = num >> n;
    r = num & ((1 << n) - 1);
    if (q >= SUM_FRAC + 2) return 0;
    m = 64'd1 << 62;
    for (int j = 0; j < n; j++) begin
      if (r[j]) m = q62_mul(m, root2_q62[n - j]);
    end
    sh = 62 - SUM_FRAC + int'(q);
    if (round_up) m = m + (64'd1 << (sh - 1));
    return m >> sh;
  endfunction

  function automatic void build_tables();
    root2_q62[0] = 64'd1 << 61;
    for (int k = 1; k <= LOG_FRAC + 1; k++) root2_q62[k] = q62_sqrt(root2_q62[k-1]);
    for (int i = 0; i <= 2 * LMASK; i++)
      exp2_lin[i] = SUMW'(pow2_scaled(i, LOG_FRAC, 1'b1));
    for (int i = 0; i <= LMASK; i++)
      log_thresh[i] = longint'(pow2_scaled(2 * i + 1, LOG_FRAC + 1, 1'b0));
  endfunction

  // Fold one element into the accumulator; queue the activation on a last element
  function automatic void accumulate_item(input neuron_in_t it);
    int unsigned lwx;
    longint      s;
    longint      a;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    neuron_out_t res;
    lwx = (it.act_log & LMASK) + (it.wt_log & LMASK);
    s   = it.first ? longint'($signed(it.bias)) : longint'(acc_reg);
    if (it.wt_neg) s = s - longint'(exp2_lin[lwx]);
    else           s = s + longint'(exp2_lin[lwx]);
    if (s > 64'sd2147483647)  s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    acc_reg = int'(s);
    if (!it.last) return;
    res.clipped = (s <= 0);
    if (layer_mode) begin
      res.activation = (s <= 0) ? 31'd0 : 31'(s);
    end else if (s <= 0) begin
      res.activation = 31'(LMASK);
    end else begin
      a  = (s > (64'sd1 << SUM_FRAC)) ? (64'sd1 << SUM_FRAC) : s;
      lo = 0;
      hi = LMASK;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (log_thresh[mid] >= a) lo = mid + 1;
        else hi = mid;
      end
      res.activation = 31'(lo);
    end
    pending_acts.push_back(res);
  endfunction

  function automatic void add_item(input logic [7:0] act, input logic [7:0] wt,
                                   input logic neg, input logic [23:0] bias,
                                   input logic first, input logic last);
    stim_items.push_back('{act, wt, neg, bias, first, last});
    pushed_cnt++;
  endfunction

  function automatic logic [7:0] rand_log();
    if ($urandom_range(99) < 30) return 8'($urandom);
    return 8'($urandom_range(90));
  endfunction

  function automatic logic [23:0] rand_bias();
    int v;
    case ($urandom_range(9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2, 3:    return 24'($urandom);
      default: begin
        v = int'($urandom_range(1200)) - 600;
        return 24'(v);
      end
    endcase
  endfunction

  // Mostly well-formed neurons with random content, some stray elements
  task automatic add_random(input int count);
    int made;
    int len;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 15) begin
        add_item(rand_log(), rand_log(), 1'($urandom), rand_bias(), 1'($urandom),
                 1'($urandom));
        made++;
      end else begin
        len = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
        for (int k = 0; k < len; k++)
          add_item(rand_log(), rand_log(), $urandom_range(9) < 3, rand_bias(), k == 0,
                   k == len - 1);
        made += len;
      end
    end
  endtask

  // Wait until every element is taken and every activation is back, then let the pipe empty
  task automatic drain();
    while (taken_cnt != pushed_cnt || pending_acts.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    layer_mode = v;
  endtask

  // Sender: offer queued elements, predict on each accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        accumulate_item(on_bus);
        taken_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stim_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          on_bus = stim_items.pop_front();
          s_axis_tdata  <= S_TDATA_W'({on_bus.bias, on_bus.wt_neg, on_bus.wt_log,
                                       on_bus.act_log});
          s_axis_tuser  <= on_bus.first;
          s_axis_tlast  <= on_bus.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transaction against the oldest prediction
  always @(posedge clk_i) begin : result_check
    neuron_out_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_acts.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("unexpected result: activation %0d clipped_low %b",
                     m_axis_tdata, m_axis_tuser);
        end else begin
          want = pending_acts.pop_front();
          if (m_axis_tdata !== M_TDATA_W'(want.activation) ||
              m_axis_tuser !== want.clipped) begin
            mism_cnt++;
            if (mism_cnt <= 10)
              $display("result %0d: expected activation %0d clipped_low %b, got %0d %b",
                       taken_cnt, want.activation, want.clipped, m_axis_tdata,
                       m_axis_tuser);
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Long receiver hold-off so the queue fills and back-pressures the input
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    build_tables();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hidden layer, straight after reset
    add_item(8'd0,   8'd0,   1'b0, 24'd0,     1'b1, 1'b1);  // product of one
    add_item(8'd255, 8'd255, 1'b1, 24'h7FFFFF, 1'b1, 1'b1); // tiny product, capped acc
    add_item(8'd0,   8'd0,   1'b1, 24'h800000, 1'b1, 1'b1); // most negative
    add_item(8'd0,   8'd0,   1'b0, 24'hFFFF00, 1'b1, 1'b1); // acc exactly zero
    add_item(8'd70,  8'd70,  1'b0, 24'd0,     1'b1, 1'b1);  // acc of one lsb
    add_item(8'd100, 8'd44,  1'b0, 24'd0,     1'b1, 1'b1);  // top table octave
    add_item(8'd80,  8'd80,  1'b0, 24'd100,   1'b1, 1'b1);  // past the table
    add_item(8'd8,   8'd8,   1'b0, 24'd0,     1'b1, 1'b0);
    add_item(8'd16,  8'd0,   1'b1, 24'hABCDEF, 1'b0, 1'b0);
    add_item(8'd3,   8'd5,   1'b0, 24'h123456, 1'b0, 1'b0);
    add_item(8'd0,   8'd33,  1'b0, 24'd0,     1'b0, 1'b1);
    add_item(8'd0,   8'd0,   1'b1, 24'd64,    1'b1, 1'b0);
    add_item(8'd20,  8'd20,  1'b1, 24'd0,     1'b0, 1'b1);  // driven negative
    add_item(8'd40,  8'd0,   1'b0, 24'd0,     1'b0, 1'b1);  // carry on without reload
    add_item(8'd255, 8'd0,   1'b0, 24'd100,   1'b1, 1'b1);
    drain();

    // Last layer: linear output
    set_mode(1'b1);
    add_item(8'd0,   8'd0,   1'b0, 24'h7FFFFF, 1'b1, 1'b1);
    add_item(8'd0,   8'd0,   1'b1, 24'h800000, 1'b1, 1'b1);
    add_item(8'd0,   8'd0,   1'b0, 24'hFFFF00, 1'b1, 1'b1);
    add_item(8'd10,  8'd20,  1'b1, 24'd1000,  1'b1, 1'b0);
    add_item(8'd0,   8'd0,   1'b0, 24'd0,     1'b0, 1'b1);
    add_item(8'd255, 8'd255, 1'b0, 24'd0,     1'b1, 1'b1);
    add_item(8'd0,   8'd0,   1'b0, 24'h800000, 1'b0, 1'b1);
    drain();

    // Random phases: alternate the mode, walk through the idle profiles
    for (int p = 0; p < 8; p++) begin
      set_mode(p[0]);
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 54; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 54; end
        default: begin src_idle_pct = 19; snk_stall_pct = 19; end
      endcase
      add_random(PHASE_ITEMS);
      if (p == 0) hold_go = 1'b1;
      drain();
    end

    if (mism_cnt == 0 && pending_acts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
